>>> rtl/stok_pkg.sv
// shared types, constants and character helpers for the source tokenizer
package stok_pkg;

	typedef enum logic [3:0] {
		M_IDLE, M_SLASH, M_OP, M_UNDER, M_IDENT, M_NUMBER, M_NUMDOT,
		M_STRING, M_ESCAPE, M_LINECMT, M_BLOCK, M_BLOCKSTAR
	} mode_t;

	localparam logic [4:0] K_EOF    = 5'd0;
	localparam logic [4:0] K_SLASH  = 5'd13;
	localparam logic [4:0] K_UNDER  = 5'd24;
	localparam logic [4:0] K_IDENT  = 5'd25;
	localparam logic [4:0] K_STRING = 5'd26;
	localparam logic [4:0] K_INT    = 5'd27;
	localparam logic [4:0] K_FLOAT  = 5'd28;

	localparam logic [2:0] E_NONE    = 3'd0;
	localparam logic [2:0] E_UNEXP   = 3'd1;
	localparam logic [2:0] E_ESCAPE  = 3'd2;
	localparam logic [2:0] E_NEWLINE = 3'd3;
	localparam logic [2:0] E_UNTSTR  = 3'd4;
	localparam logic [2:0] E_UNTCMT  = 3'd5;

	localparam logic [7:0] C_LF    = 8'h0a;
	localparam logic [7:0] C_UNDER = 8'h5f;
	localparam logic [7:0] C_DOT   = 8'h2e;
	localparam logic [7:0] C_QUOTE = 8'h22;
	localparam logic [7:0] C_BSL   = 8'h5c;
	localparam logic [7:0] C_STAR  = 8'h2a;
	localparam logic [7:0] C_SLASH = 8'h2f;

	localparam int TDATA_BITS = 88;

	// one result: kind, error, line, column, offset, length, last
	typedef struct packed {
		logic [4:0]  kind;
		logic [2:0]  err;
		logic [15:0] line;
		logic [15:0] col;
		logic [31:0] off;
		logic [15:0] len;
		logic        last;
	} result_t;

	// up to three results of one byte, in order
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
		result_t    r2;
	} bundle_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		unique case (c)
			8'h28: return 5'd1;
			8'h29: return 5'd2;
			8'h7b: return 5'd3;
			8'h7d: return 5'd4;
			8'h5b: return 5'd5;
			8'h5d: return 5'd6;
			8'h2c: return 5'd7;
			8'h2b: return 5'd8;
			8'h2a: return 5'd9;
			8'h25: return 5'd10;
			8'h3b: return 5'd11;
			8'h3a: return 5'd12;
			default: return 5'd0;
		endcase
	endfunction

	function automatic logic [4:0] op_kind(input logic [7:0] c);
		unique case (c)
			8'h3d: return 5'd14;
			8'h2d: return 5'd16;
			8'h21: return 5'd18;
			8'h3c: return 5'd20;
			8'h3e: return 5'd22;
			default: return 5'd0;
		endcase
	endfunction

endpackage

>>> rtl/stok_front.sv
// front part: input handshake, position tracking and scanner state
module stok_front #(
	parameter int POSITION_BITS = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_ch,
	input  logic              in_eoi,
	output logic              push,
	output stok_pkg::bundle_t push_data,
	input  logic              q_ready
);
	import stok_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	mode_t mode_q;
	logic [7:0] pend_q;
	logic [POSITION_BITS-1:0] line_q, col_q, tline_q, tcol_q, dline_q, dcol_q;
	logic [OFFSET_BITS-1:0] off_q, toff_q, doff_q;
	logic [15:0] len_q;
	logic fdot_q;

	mode_t mode_n;
	logic [7:0] pend_n;
	logic [POSITION_BITS-1:0] tline_n, tcol_n, dline_n, dcol_n;
	logic [OFFSET_BITS-1:0] toff_n, doff_n;
	logic [15:0] len_n;
	logic fdot_n;
	result_t res [3];
	logic [1:0] cnt;
	logic go;
	logic [7:0] c;
	logic rescan;

	assign in_ready = q_ready;
	assign go = in_valid && q_ready;
	assign c = in_ch;

	function automatic logic [15:0] sat(input logic [POSITION_BITS-1:0] v);
		if (POSITION_BITS > 16 && (v >> 16) != '0)
			return 16'hffff;
		return 16'(v);
	endfunction

	function automatic logic [15:0] inc(input logic [15:0] v);
		return (v == 16'hffff) ? v : v + 16'd1;
	endfunction

	always_comb begin
		result_t rt;
		result_t rh;
		result_t rd;
		rt = '{kind: K_EOF, err: E_NONE, line: sat(tline_q), col: sat(tcol_q),
			off: 32'(toff_q), len: len_q, last: 1'b0};
		rh = '{kind: K_EOF, err: E_UNEXP, line: sat(line_q), col: sat(col_q),
			off: 32'(off_q), len: 16'd1, last: 1'b0};
		rd = '{kind: K_EOF, err: E_UNEXP, line: sat(dline_q), col: sat(dcol_q),
			off: 32'(doff_q), len: 16'd1, last: 1'b0};
		mode_n = mode_q;
		pend_n = pend_q;
		tline_n = tline_q;
		tcol_n = tcol_q;
		toff_n = toff_q;
		dline_n = dline_q;
		dcol_n = dcol_q;
		doff_n = doff_q;
		len_n = len_q;
		fdot_n = fdot_q;
		cnt = 2'd0;
		res[0] = rt;
		res[1] = rt;
		res[2] = rt;
		rescan = 1'b0;
		if (in_eoi) begin
			unique case (mode_q)
				M_SLASH: begin res[0].kind = K_SLASH; cnt = 2'd1; end
				M_OP: begin res[0].kind = op_kind(pend_q); cnt = 2'd1; end
				M_UNDER: begin res[0].kind = K_UNDER; cnt = 2'd1; end
				M_IDENT: begin res[0].kind = K_IDENT; cnt = 2'd1; end
				M_NUMBER: begin
					res[0].kind = fdot_q ? K_FLOAT : K_INT;
					cnt = 2'd1;
				end
				M_NUMDOT: begin
					res[0].kind = K_INT;
					res[1] = rd;
					cnt = 2'd2;
				end
				M_STRING, M_ESCAPE: begin res[0].err = E_UNTSTR; cnt = 2'd1; end
				M_BLOCK, M_BLOCKSTAR: begin res[0].err = E_UNTCMT; cnt = 2'd1; end
				default: ;
			endcase
			res[cnt] = rh;
			res[cnt].err = E_NONE;
			res[cnt].len = 16'd0;
			cnt = cnt + 2'd1;
			mode_n = M_IDLE;
			fdot_n = 1'b0;
		end else begin
			unique case (mode_q)
				M_SLASH: begin
					if (c == C_SLASH) mode_n = M_LINECMT;
					else if (c == C_STAR) begin
						len_n = inc(len_q);
						mode_n = M_BLOCK;
					end else begin
						res[0].kind = K_SLASH; cnt = 2'd1; rescan = 1'b1;
					end
				end
				M_OP: begin
					if (c == ((pend_q == 8'h2d) ? 8'h3e : 8'h3d)) begin
						res[0].kind = op_kind(pend_q) + 5'd1;
						res[0].len = 16'd2;
						len_n = 16'd2;
						cnt = 2'd1;
						mode_n = M_IDLE;
					end else begin
						res[0].kind = op_kind(pend_q); cnt = 2'd1; rescan = 1'b1;
					end
				end
				M_UNDER: begin
					if (is_alpha(c)) begin
						len_n = inc(len_q);
						mode_n = M_IDENT;
					end else begin
						res[0].kind = K_UNDER; cnt = 2'd1; rescan = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == C_UNDER) len_n = inc(len_q);
					else begin
						res[0].kind = K_IDENT; cnt = 2'd1; rescan = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_digit(c)) len_n = inc(len_q);
					else if (c == C_DOT && !fdot_q) begin
						mode_n = M_NUMDOT;
						pend_n = c;
						dline_n = line_q;
						dcol_n = col_q;
						doff_n = off_q;
					end else begin
						res[0].kind = fdot_q ? K_FLOAT : K_INT;
						cnt = 2'd1;
						rescan = 1'b1;
					end
				end
				M_NUMDOT: begin
					if (is_digit(c)) begin
						len_n = inc(inc(len_q));
						fdot_n = 1'b1;
						mode_n = M_NUMBER;
					end else begin
						res[0].kind = K_INT;
						res[1] = rd;
						cnt = 2'd2;
						rescan = 1'b1;
					end
				end
				M_STRING: begin
					if (c == C_LF) begin
						res[0] = rh;
						res[0].err = E_NEWLINE;
						res[1].len = 16'd0;
						cnt = 2'd2;
						rescan = 1'b1;
					end else begin
						len_n = inc(len_q);
						if (c == C_QUOTE) begin
							res[0].kind = K_STRING;
							res[0].len = len_n;
							cnt = 2'd1;
							mode_n = M_IDLE;
						end else if (c == C_BSL) mode_n = M_ESCAPE;
					end
				end
				M_ESCAPE: begin
					if (c == 8'h6e || c == 8'h74 || c == C_QUOTE || c == C_BSL) begin
						len_n = inc(len_q);
						mode_n = M_STRING;
					end else begin
						res[0] = rh;
						res[0].err = E_ESCAPE;
						res[1].len = 16'd0;
						cnt = 2'd2;
						rescan = 1'b1;
					end
				end
				M_LINECMT: begin
					if (c == C_LF) mode_n = M_IDLE;
				end
				M_BLOCK, M_BLOCKSTAR: begin
					len_n = inc(len_q);
					if (c == C_STAR) mode_n = M_BLOCKSTAR;
					else if (c == C_SLASH && mode_q == M_BLOCKSTAR) mode_n = M_IDLE;
					else mode_n = M_BLOCK;
				end
				default: rescan = 1'b1;
			endcase
			if (rescan) begin
				mode_n = M_IDLE;
				if (!is_space(c)) begin
					if (punct_kind(c) != 5'd0 || c == C_SLASH || op_kind(c) != 5'd0
						|| c == C_UNDER || c == C_QUOTE || is_alpha(c) || is_digit(c)) begin
						tline_n = line_q;
						tcol_n = col_q;
						toff_n = off_q;
						len_n = 16'd1;
						fdot_n = 1'b0;
					end
					priority if (punct_kind(c) != 5'd0) begin
						res[cnt] = '{kind: punct_kind(c), err: E_NONE, line: sat(line_q),
							col: sat(col_q), off: 32'(off_q), len: 16'd1, last: 1'b0};
						cnt = cnt + 2'd1;
					end else if (c == C_SLASH) mode_n = M_SLASH;
					else if (op_kind(c) != 5'd0) begin
						mode_n = M_OP;
						pend_n = c;
					end else if (c == C_UNDER) mode_n = M_UNDER;
					else if (c == C_QUOTE) mode_n = M_STRING;
					else if (is_alpha(c)) mode_n = M_IDENT;
					else if (is_digit(c)) mode_n = M_NUMBER;
					else begin
						res[cnt] = rh;
						cnt = cnt + 2'd1;
					end
				end
			end
		end
		if (cnt != 2'd0) res[cnt - 2'd1].last = 1'b1;
	end

	assign push = go && cnt != 2'd0;
	assign push_data = '{count: cnt, r0: res[0], r1: res[1], r2: res[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= '0;
			line_q <= POSITION_BITS'(1);
			col_q <= POSITION_BITS'(1);
			off_q <= '0;
			tline_q <= POSITION_BITS'(1);
			tcol_q <= POSITION_BITS'(1);
			toff_q <= '0;
			dline_q <= POSITION_BITS'(1);
			dcol_q <= POSITION_BITS'(1);
			doff_q <= '0;
			len_q <= '0;
			fdot_q <= 1'b0;
		end else if (go) begin
			mode_q <= mode_n;
			pend_q <= pend_n;
			tline_q <= tline_n;
			tcol_q <= tcol_n;
			toff_q <= toff_n;
			dline_q <= dline_n;
			dcol_q <= dcol_n;
			doff_q <= doff_n;
			len_q <= len_n;
			fdot_q <= fdot_n;
			if (!in_eoi) begin
				if (c == C_LF) begin
					if (line_q != POS_MAX) line_q <= line_q + POSITION_BITS'(1);
					col_q <= POSITION_BITS'(1);
				end else if (col_q != POS_MAX) col_q <= col_q + POSITION_BITS'(1);
				off_q <= off_q + OFFSET_BITS'(1);
			end
		end
	end

endmodule

>>> rtl/stok_queue.sv
// short queue of result bundles between front and back
module stok_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  stok_pkg::bundle_t push_data,
	output logic              can_push,
	output logic              pop_valid,
	output stok_pkg::bundle_t pop_data,
	input  logic              pop
);
	import stok_pkg::*;

	bundle_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] fill_q;

	assign can_push = fill_q < 3'd3 || pop;
	assign pop_valid = fill_q != 3'd0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			fill_q <= fill_q + 3'(push) - 3'(pop);
		end
	end

endmodule

>>> rtl/stok_back.sv
// back part: sends the results of one bundle, one transaction each
module stok_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  stok_pkg::bundle_t q_data,
	output logic              q_pop,
	output logic              m_valid,
	input  logic              m_ready,
	output stok_pkg::result_t m_res
);
	import stok_pkg::*;

	logic [1:0] idx_q;

	assign m_valid = q_valid;
	always_comb begin
		unique case (idx_q)
			2'd0: m_res = q_data.r0;
			2'd1: m_res = q_data.r1;
			default: m_res = q_data.r2;
		endcase
	end
	assign q_pop = q_valid && m_ready && (idx_q + 2'd1 == q_data.count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= '0;
		else if (q_pop) idx_q <= '0;
		else if (q_valid && m_ready) idx_q <= idx_q + 2'd1;
	end

endmodule

>>> rtl/source_tokenizer.sv
// top level of the streaming source tokenizer
// One source byte (or end marker) is taken per cycle while the result queue
// has room for another bundle (it holds three); each byte yields zero to three
// result transactions, sent one per cycle while m_tready is high, so output
// bandwidth sets the sustained rate when tokens are dense. Each bundle is
// registered in the queue before its first result is sent.
module source_tokenizer #(
	parameter int POSITION_BITS = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // ch
	input  logic         s_tuser,  // end_of_input
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [stok_pkg::TDATA_BITS-1:0] m_tdata,
	// token_kind, error_code, start_line, start_column, start_offset, token_length
	output logic         m_tlast
);
	import stok_pkg::*;

	logic push, can_push, qv, pop;
	bundle_t pd, qd;
	result_t r;

	stok_front #(.POSITION_BITS(POSITION_BITS), .OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_ch(s_tdata),
		.in_eoi(s_tuser), .push, .push_data(pd), .q_ready(can_push));

	stok_queue u_queue (.clk, .arst_n, .push, .push_data(pd), .can_push,
		.pop_valid(qv), .pop_data(qd), .pop);

	stok_back u_back (.clk, .arst_n, .q_valid(qv), .q_data(qd), .q_pop(pop),
		.m_valid(m_tvalid), .m_ready(m_tready), .m_res(r));

	assign m_tdata = {r.len, r.off, r.col, r.line, r.err, r.kind};
	assign m_tlast = r.last;

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		qv |-> qd.count != 2'd0) else $error("empty bundle queued");
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> s_tvalid && s_tready) else $error("push without transaction");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> m_tlast) else $error("bundle ended without last");

endmodule
